### sv/el_pkg.sv
// el_pkg: shared types, codes and character helpers for the expression lexer
// depends on nothing; used by el_step, el_tok_fifo and expression_lexer
package el_pkg;

	// saturation point of the byte counter
	localparam logic [16:0] POS_CAP = 17'd65535;

	// tokens one item can cause at most, and depth of the token queue
	localparam int MAX_TOKS   = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = FIFO_AW + 1;
	localparam int TOKN_W     = $clog2(MAX_TOKS + 1);

	typedef enum logic [4:0] {
		K_EOI      = 5'd0,
		K_INT      = 5'd1,
		K_DEC      = 5'd2,
		K_SYM      = 5'd3,
		K_COMMA    = 5'd4,
		K_LPAREN   = 5'd5,
		K_RPAREN   = 5'd6,
		K_SEMI     = 5'd7,
		K_PLUS     = 5'd8,
		K_MINUS    = 5'd9,
		K_STAR     = 5'd10,
		K_SLASH    = 5'd11,
		K_PERCENT  = 5'd12,
		K_ASSIGN   = 5'd13,
		K_EQ       = 5'd14,
		K_NE       = 5'd15,
		K_GT       = 5'd16,
		K_GE       = 5'd17,
		K_LT       = 5'd18,
		K_LE       = 5'd19,
		K_ERROR    = 5'd20
	} kind_t;

	// lexer mode, one-hot
	typedef enum logic [6:0] {
		MODE_IDLE   = 7'b0000001,
		MODE_INT    = 7'b0000010,
		MODE_INTDOT = 7'b0000100,
		MODE_DEC    = 7'b0001000,
		MODE_SYM    = 7'b0010000,
		MODE_OP     = 7'b0100000,
		MODE_ERR    = 7'b1000000
	} mode_t;

	// first character of a possible two-character operator
	typedef enum logic [1:0] {
		OP_ASSIGN = 2'd0,
		OP_BANG   = 2'd1,
		OP_GT     = 2'd2,
		OP_LT     = 2'd3
	} pop_t;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] tstart;
		logic [16:0] bpos;
		pop_t        pop;
	} st_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] pos;
		logic [15:0] len;
		logic        final_r;
	} tok_t;

	function automatic logic [15:0] sat16(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic kind_t op_single(input pop_t p);
		case (p)
			OP_ASSIGN: return K_ASSIGN;
			OP_BANG:   return K_ERROR;
			OP_GT:     return K_GT;
			default:   return K_LT;
		endcase
	endfunction

	function automatic kind_t op_pair(input pop_t p);
		case (p)
			OP_ASSIGN: return K_EQ;
			OP_BANG:   return K_NE;
			OP_GT:     return K_GE;
			default:   return K_LE;
		endcase
	endfunction

	// single-character punctuation; K_ERROR when the byte is none of them
	function automatic kind_t punct_kind(input logic [7:0] c);
		case (c)
			8'h2C:   return K_COMMA;
			8'h28:   return K_LPAREN;
			8'h29:   return K_RPAREN;
			8'h3B:   return K_SEMI;
			8'h2B:   return K_PLUS;
			8'h2D:   return K_MINUS;
			8'h2A:   return K_STAR;
			8'h2F:   return K_SLASH;
			8'h25:   return K_PERCENT;
			default: return K_ERROR;
		endcase
	endfunction

	// token from kind, start and end offsets, saturated to 16 bits
	function automatic tok_t make_tok(input kind_t k, input logic [16:0] s,
			input logic [16:0] e);
		tok_t t;
		t.kind    = k;
		t.pos     = sat16(s);
		t.len     = sat16((e > s) ? (e - s) : 17'd0);
		t.final_r = 1'b0;
		return t;
	endfunction

endpackage

### sv/el_chars_if.sv
// el_chars_if: character request channel of the expression lexer
// valid/ready handshake with one byte per request; no dependencies
interface el_chars_if;
	logic       valid;
	logic       ready;
	logic       byte_present;
	logic [7:0] char_code;
	logic       last;

	modport source(output valid, byte_present, char_code, last, input ready);
	modport sink(input valid, byte_present, char_code, last, output ready);
endinterface

### sv/el_tok_if.sv
// el_tok_if: token request channel of the expression lexer
// valid/ready handshake with one token per request; no dependencies
interface el_tok_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_pos;
	logic [15:0] token_len;
	logic        final_result;

	modport source(output valid, token_kind, token_pos, token_len, final_result,
		input ready);
	modport sink(input valid, token_kind, token_pos, token_len, final_result,
		output ready);
endinterface

### sv/expression_lexer.sv
// expression_lexer: streaming tokenizer, one byte per request in, tokens out
// tokens of an accepted request are registered into the token queue
// throughput: one byte per cycle while the four-entry token queue holds at most
// one token; each token leaves the queue in its own token channel handshake
// reset: clears lexer mode, token start, byte counter and the token queue
// depends on el_pkg, el_chars_if, el_tok_if, el_step, el_tok_fifo
module expression_lexer (
	input  logic     clk,
	input  logic     arst_n,
	el_chars_if.sink chars,
	el_tok_if.source tokens
);
	import el_pkg::*;

	st_t                      state_q;
	st_t                      st_nxt;
	tok_t [MAX_TOKS-1:0]      toks;
	logic [TOKN_W-1:0]        tok_n;
	logic                     room;
	logic                     acc;
	logic [CNT_W-1:0]         count;

	assign chars.ready = room;
	assign acc         = chars.valid && chars.ready;

	// one request of lexing logic
	el_step u_step (
		.st           (state_q),
		.byte_present (chars.byte_present),
		.char_code    (chars.char_code),
		.last         (chars.last),
		.st_nxt       (st_nxt),
		.toks         (toks),
		.tok_n        (tok_n)
	);

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode   <= MODE_IDLE;
			state_q.tstart <= '0;
			state_q.bpos   <= '0;
			state_q.pop    <= OP_ASSIGN;
		end else if (acc) begin
			state_q <= st_nxt;
		end
	end

	// token queue
	el_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_n    (tok_n),
		.push_toks (toks),
		.room      (room),
		.count     (count),
		.tokens    (tokens)
	);

	// end of input returns to the reset state
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc && chars.last |=> state_q.mode == MODE_IDLE && state_q.bpos == '0)
		else $error("state not cleared after end of input");

	// byte counter never exceeds its saturation point
	a_bpos_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bpos <= POS_CAP)
		else $error("byte counter above cap");

	// queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(FIFO_DEPTH))
		else $error("token queue overflow");

	// a byte without end of input produces at most two tokens
	a_tok_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !chars.last |-> tok_n <= TOKN_W'(2))
		else $error("too many tokens without end of input");

endmodule

### sv/el_step.sv
// el_step: next lexer state and the up to three tokens caused by one request
// depends on el_pkg
module el_step (
	input  el_pkg::st_t                      st,
	input  logic                             byte_present,
	input  logic [7:0]                       char_code,
	input  logic                             last,
	output el_pkg::st_t                      st_nxt,
	output el_pkg::tok_t [el_pkg::MAX_TOKS-1:0] toks,
	output logic [el_pkg::TOKN_W-1:0]        tok_n
);
	import el_pkg::*;

	localparam int NCAND = 4;

	always_comb begin
		tok_t                cand [NCAND];
		logic [NCAND-1:0]    cv;
		mode_t               mode1;
		logic [15:0]         ts1;
		pop_t                po1;
		logic [16:0]         pos;
		logic [16:0]         bpos1;
		logic                fresh;
		logic [TOKN_W-1:0]   n;

		for (int i = 0; i < NCAND; i++) begin
			cand[i] = make_tok(K_EOI, 17'd0, 17'd0);
		end
		cv    = '0;
		mode1 = st.mode;
		ts1   = st.tstart;
		po1   = st.pop;
		pos   = st.bpos;
		bpos1 = st.bpos;
		fresh = 1'b0;

		// byte against the pending token
		if (byte_present) begin
			case (st.mode)
				MODE_OP: begin
					cv[0] = 1'b1;
					mode1 = MODE_IDLE;
					if (char_code == CH_EQ) begin
						cand[0] = make_tok(op_pair(st.pop), {1'b0, st.tstart}, pos + 17'd1);
					end else begin
						cand[0] = make_tok(op_single(st.pop), {1'b0, st.tstart}, pos);
						fresh   = 1'b1;
					end
				end
				MODE_INT, MODE_INTDOT, MODE_DEC: begin
					if (is_digit(char_code)) begin
						if (st.mode == MODE_INTDOT) mode1 = MODE_DEC;
					end else if (char_code == CH_DOT && st.mode == MODE_INT) begin
						mode1 = MODE_INTDOT;
					end else if (is_alpha(char_code)) begin
						cv[0]   = 1'b1;
						cand[0] = make_tok(K_ERROR, {1'b0, st.tstart}, pos);
						mode1   = MODE_ERR;
					end else begin
						cv[0]   = 1'b1;
						cand[0] = make_tok((st.mode == MODE_DEC) ? K_DEC : K_INT,
							{1'b0, st.tstart}, pos);
						mode1   = MODE_IDLE;
						fresh   = 1'b1;
					end
				end
				MODE_SYM: begin
					if (!(is_alpha(char_code) || is_digit(char_code) ||
							char_code == CH_UNDER)) begin
						cv[0]   = 1'b1;
						cand[0] = make_tok(K_SYM, {1'b0, st.tstart}, pos);
						mode1   = MODE_IDLE;
						fresh   = 1'b1;
					end
				end
				MODE_ERR: begin
				end
				default: begin
					mode1 = MODE_IDLE;
					fresh = 1'b1;
				end
			endcase

			// byte that starts something new
			if (fresh) begin
				if (is_space(char_code)) begin
				end else if (is_digit(char_code)) begin
					ts1   = sat16(pos);
					mode1 = MODE_INT;
				end else if (is_alpha(char_code) || char_code == CH_UNDER) begin
					ts1   = sat16(pos);
					mode1 = MODE_SYM;
				end else if (char_code == CH_EQ || char_code == CH_BANG ||
						char_code == CH_GT || char_code == CH_LT) begin
					ts1   = sat16(pos);
					mode1 = MODE_OP;
					if (char_code == CH_EQ)        po1 = OP_ASSIGN;
					else if (char_code == CH_BANG) po1 = OP_BANG;
					else if (char_code == CH_GT)   po1 = OP_GT;
					else                           po1 = OP_LT;
				end else begin
					cv[1]   = 1'b1;
					cand[1] = make_tok(punct_kind(char_code), pos, pos + 17'd1);
				end
			end

			bpos1 = (pos < POS_CAP) ? pos + 17'd1 : POS_CAP;
		end

		// end of input: flush, eoi, back to reset state
		st_nxt.mode   = mode1;
		st_nxt.tstart = ts1;
		st_nxt.bpos   = bpos1;
		st_nxt.pop    = po1;
		if (last) begin
			case (mode1)
				MODE_INT, MODE_INTDOT: begin
					cv[2] = 1'b1;
					cand[2] = make_tok(K_INT, {1'b0, ts1}, bpos1);
				end
				MODE_DEC: begin
					cv[2] = 1'b1;
					cand[2] = make_tok(K_DEC, {1'b0, ts1}, bpos1);
				end
				MODE_SYM: begin
					cv[2] = 1'b1;
					cand[2] = make_tok(K_SYM, {1'b0, ts1}, bpos1);
				end
				MODE_OP: begin
					cv[2] = 1'b1;
					cand[2] = make_tok(op_single(po1), {1'b0, ts1}, bpos1);
				end
				default: begin
				end
			endcase
			cv[3]   = 1'b1;
			cand[3] = make_tok(K_EOI, bpos1, bpos1);
			st_nxt.mode   = MODE_IDLE;
			st_nxt.tstart = '0;
			st_nxt.bpos   = '0;
			st_nxt.pop    = OP_ASSIGN;
		end

		// pack the valid candidates in order
		toks = '0;
		n    = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cv[i] && n < TOKN_W'(MAX_TOKS)) begin
				toks[n[$clog2(MAX_TOKS)-1:0]] = cand[i];
				n = n + TOKN_W'(1);
			end
		end
		for (int j = 0; j < MAX_TOKS; j++) begin
			toks[j].final_r = (TOKN_W'(j + 1) == n);
		end
		tok_n = n;
	end

endmodule

### sv/el_tok_fifo.sv
// el_tok_fifo: small token queue, takes up to three tokens a cycle, gives one
// per token channel handshake; depends on el_pkg and el_tok_if
module el_tok_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [el_pkg::TOKN_W-1:0]        push_n,
	input  el_pkg::tok_t [el_pkg::MAX_TOKS-1:0] push_toks,
	output logic                             room,
	output logic [el_pkg::CNT_W-1:0]         count,
	el_tok_if.source                         tokens
);
	import el_pkg::*;

	tok_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;
	logic [CNT_W-1:0]   n_in;

	assign pop  = tokens.valid && tokens.ready;
	assign n_in = push ? CNT_W'(push_n) : '0;
	assign room = cnt_q <= CNT_W'(FIFO_DEPTH - MAX_TOKS);
	assign count = cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + n_in[FIFO_AW-1:0];
			if (pop) rptr_q <= rptr_q + FIFO_AW'(1);
			cnt_q <= cnt_q + n_in - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// entry writes, up to three consecutive slots
	always_ff @(posedge clk) begin
		for (int e = 0; e < FIFO_DEPTH; e++) begin
			logic [FIFO_AW-1:0] off;
			off = FIFO_AW'(e) - wptr_q;
			if (push && CNT_W'(off) < n_in) begin
				mem_q[e] <= push_toks[off[$clog2(MAX_TOKS)-1:0]];
			end
		end
	end

	// head of queue drives the channel
	assign tokens.valid        = cnt_q != '0;
	assign tokens.token_kind   = mem_q[rptr_q].kind;
	assign tokens.token_pos    = mem_q[rptr_q].pos;
	assign tokens.token_len    = mem_q[rptr_q].len;
	assign tokens.final_result = mem_q[rptr_q].final_r;

endmodule
